/* design/npbc_pkg.sv */
`default_nettype none

package npbc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int IDX_BITS   = 10;
    localparam int SLOT_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int DIST_BITS  = SQ_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic        [IDX_BITS-1:0]   idx;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } box_t;

    typedef enum logic {
        ST_LOAD,
        ST_SEARCH
    } state_t;

endpackage

`default_nettype wire

/* design/nearest_point_to_bbox_center_unit.sv */
`default_nettype none

// Entries are taken one per cycle while busy is low; valid points go into a
// 1024-deep point memory and the bounding box is tracked as they arrive. An
// entry with entry_last high starts the search: busy goes high and the memory
// is read once per stored point, one read a cycle, through a read/distance/compare
// pipeline (read register, then magnitude, square and sum stages), and busy stays
// high until the last point is compared. The result then shows on the
// outputs for one cycle with done high, and the receiver cannot stall it;
// busy is already low in that cycle. A last entry with no stored point gives
// its result (found low, zeros) in the next cycle without raising busy. No
// clearing pass is needed after reset.
module nearest_point_to_bbox_center_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [npbc_pkg::COORD_BITS-1:0] pos_x,
    input  wire logic signed [npbc_pkg::COORD_BITS-1:0] pos_y,
    input  wire logic signed [npbc_pkg::COORD_BITS-1:0] pos_z,
    input  wire logic                                   entry_valid,
    input  wire logic                                   entry_last,
    output logic                                        done,
    output logic signed [npbc_pkg::COORD_BITS-1:0]      near_x,
    output logic signed [npbc_pkg::COORD_BITS-1:0]      near_y,
    output logic signed [npbc_pkg::COORD_BITS-1:0]      near_z,
    output logic        [npbc_pkg::IDX_BITS-1:0]        near_index,
    output logic                                        found,
    output logic                                        overflow
);
    import npbc_pkg::*;

    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_POINTS);

    point_t mem [MAX_POINTS];

    state_t               state_reg, state_next;
    box_t                 box_reg, box_next;
    logic [CNT_BITS-1:0]  stored_cnt_reg, stored_cnt_next;
    logic [IDX_BITS-1:0]  entry_cnt_reg, entry_cnt_next;
    logic                 dropped_reg, dropped_next;
    logic [CNT_BITS-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [CNT_BITS-1:0]  cmp_cnt_reg, cmp_cnt_next;
    logic                 rd_valid_reg;
    point_t               rdata_reg;
    logic [DIST_BITS-1:0] best_dist_reg, best_dist_next;
    point_t               best_pt_reg, best_pt_next;
    logic                 have_best_reg, have_best_next;
    logic                 done_reg, done_next;
    point_t               res_pt_reg, res_pt_next;
    logic                 found_reg, found_next;
    logic                 ovf_reg, ovf_next;

    logic                 accept;
    logic                 full;
    logic                 wr_en;
    logic                 rd_en;
    point_t               in_pt;
    logic                 d_valid;
    point_t               d_pt;
    logic [DIST_BITS-1:0] d_dist;
    logic                 better;
    logic                 last_cmp;

    assign busy   = (state_reg == ST_SEARCH);
    assign accept = start && !busy;
    assign full   = (stored_cnt_reg >= MAX_CNT);
    assign wr_en  = accept && entry_valid && !full;
    assign rd_en  = (state_reg == ST_SEARCH) && (rd_cnt_reg != stored_cnt_reg);

    assign in_pt.x   = pos_x;
    assign in_pt.y   = pos_y;
    assign in_pt.z   = pos_z;
    assign in_pt.idx = entry_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[stored_cnt_reg[SLOT_BITS-1:0]] <= in_pt;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_cnt_reg[SLOT_BITS-1:0]];
        end
    end

    npbc_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_pt     (rdata_reg),
        .box       (box_reg),
        .out_valid (d_valid),
        .out_pt    (d_pt),
        .out_dist  (d_dist)
    );

    assign better   = d_valid && (!have_best_reg || (d_dist < best_dist_reg));
    assign last_cmp = d_valid && (cmp_cnt_reg == stored_cnt_reg - CNT_BITS'(1));

    always_comb
    begin
        state_next      = state_reg;
        box_next        = box_reg;
        stored_cnt_next = stored_cnt_reg;
        entry_cnt_next  = entry_cnt_reg;
        dropped_next    = dropped_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_cnt_next    = cmp_cnt_reg;
        best_dist_next  = best_dist_reg;
        best_pt_next    = best_pt_reg;
        have_best_next  = have_best_reg;
        done_next       = 1'b0;
        res_pt_next     = res_pt_reg;
        found_next      = found_reg;
        ovf_next        = ovf_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    entry_cnt_next = entry_cnt_reg + IDX_BITS'(1);
                    if (wr_en)
                    begin
                        stored_cnt_next = stored_cnt_reg + CNT_BITS'(1);
                        if (stored_cnt_reg == '0)
                        begin
                            box_next = '{pos_x, pos_y, pos_z, pos_x, pos_y, pos_z};
                        end
                        else
                        begin
                            if (pos_x < box_reg.min_x) box_next.min_x = pos_x;
                            if (pos_y < box_reg.min_y) box_next.min_y = pos_y;
                            if (pos_z < box_reg.min_z) box_next.min_z = pos_z;
                            if (pos_x > box_reg.max_x) box_next.max_x = pos_x;
                            if (pos_y > box_reg.max_y) box_next.max_y = pos_y;
                            if (pos_z > box_reg.max_z) box_next.max_z = pos_z;
                        end
                    end
                    else if (entry_valid)
                    begin
                        dropped_next = 1'b1;
                    end

                    if (entry_last)
                    begin
                        if (stored_cnt_next == '0)
                        begin
                            // empty list: zero result right away
                            done_next       = 1'b1;
                            res_pt_next     = '0;
                            found_next      = 1'b0;
                            ovf_next        = dropped_next;
                            box_next        = '0;
                            stored_cnt_next = '0;
                            entry_cnt_next  = '0;
                            dropped_next    = 1'b0;
                        end
                        else
                        begin
                            state_next     = ST_SEARCH;
                            rd_cnt_next    = '0;
                            cmp_cnt_next   = '0;
                            have_best_next = 1'b0;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_BITS'(1);
                end
                if (d_valid)
                begin
                    cmp_cnt_next = cmp_cnt_reg + CNT_BITS'(1);
                    if (better)
                    begin
                        best_dist_next = d_dist;
                        best_pt_next   = d_pt;
                        have_best_next = 1'b1;
                    end
                end
                if (last_cmp)
                begin
                    done_next       = 1'b1;
                    res_pt_next     = better ? d_pt : best_pt_reg;
                    found_next      = 1'b1;
                    ovf_next        = dropped_reg;
                    state_next      = ST_LOAD;
                    box_next        = '0;
                    stored_cnt_next = '0;
                    entry_cnt_next  = '0;
                    dropped_next    = 1'b0;
                    have_best_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            box_reg        <= '0;
            stored_cnt_reg <= '0;
            entry_cnt_reg  <= '0;
            dropped_reg    <= 1'b0;
            rd_cnt_reg     <= '0;
            cmp_cnt_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            have_best_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            box_reg        <= box_next;
            stored_cnt_reg <= stored_cnt_next;
            entry_cnt_reg  <= entry_cnt_next;
            dropped_reg    <= dropped_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_cnt_reg    <= cmp_cnt_next;
            rd_valid_reg   <= rd_en;
            have_best_reg  <= have_best_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_pt_reg   <= best_pt_next;
        res_pt_reg    <= res_pt_next;
        found_reg     <= found_next;
        ovf_reg       <= ovf_next;
    end

    assign done       = done_reg;
    assign near_x     = res_pt_reg.x;
    assign near_y     = res_pt_reg.y;
    assign near_z     = res_pt_reg.z;
    assign near_index = res_pt_reg.idx;
    assign found      = found_reg;
    assign overflow   = ovf_reg;

endmodule

`default_nettype wire

/* design/npbc_dist.sv */
`default_nettype none

module npbc_dist (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire npbc_pkg::point_t               in_pt,
    input  wire npbc_pkg::box_t                 box,
    output logic                                out_valid,
    output npbc_pkg::point_t                    out_pt,
    output logic [npbc_pkg::DIST_BITS-1:0]      out_dist
);
    import npbc_pkg::*;

    logic                  va_reg, vb_reg, vc_reg;
    point_t                pa_reg, pb_reg, pc_reg;
    logic [MAG_BITS-1:0]   ma_x_reg, ma_y_reg, ma_z_reg;
    logic [SQ_BITS-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DIST_BITS-1:0]  dist_reg;

    logic signed [DIFF_BITS-1:0] d_x, d_y, d_z;
    logic        [MAG_BITS-1:0]  m_x, m_y, m_z;

    function automatic logic signed [DIFF_BITS-1:0] axis_diff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] lo,
        input logic signed [COORD_BITS-1:0] hi
    );
        logic signed [DIFF_BITS-1:0] p2;
        logic signed [DIFF_BITS-1:0] s;
        p2 = DIFF_BITS'(p) <<< 1;
        s  = DIFF_BITS'(lo) + DIFF_BITS'(hi);
        return p2 - s;
    endfunction

    function automatic logic [MAG_BITS-1:0] axis_mag(input logic signed [DIFF_BITS-1:0] d);
        logic [DIFF_BITS-1:0] a;
        a = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
        return a[MAG_BITS-1:0];
    endfunction

    always_comb
    begin
        d_x = axis_diff(in_pt.x, box.min_x, box.max_x);
        d_y = axis_diff(in_pt.y, box.min_y, box.max_y);
        d_z = axis_diff(in_pt.z, box.min_z, box.max_z);
        m_x = axis_mag(d_x);
        m_y = axis_mag(d_y);
        m_z = axis_mag(d_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // magnitude, square, sum
    always_ff @(posedge clk)
    begin
        pa_reg   <= in_pt;
        ma_x_reg <= m_x;
        ma_y_reg <= m_y;
        ma_z_reg <= m_z;
        pb_reg   <= pa_reg;
        sq_x_reg <= ma_x_reg * ma_x_reg;
        sq_y_reg <= ma_y_reg * ma_y_reg;
        sq_z_reg <= ma_z_reg * ma_z_reg;
        pc_reg   <= pb_reg;
        dist_reg <= DIST_BITS'(sq_x_reg) + DIST_BITS'(sq_y_reg) + DIST_BITS'(sq_z_reg);
    end

    assign out_valid = vc_reg;
    assign out_pt    = pc_reg;
    assign out_dist  = dist_reg;

endmodule

`default_nettype wire

/* design/npbc_checker.sv */
`default_nettype none

module npbc_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   start,
    input wire logic                                   busy,
    input wire logic signed [npbc_pkg::COORD_BITS-1:0] pos_x,
    input wire logic signed [npbc_pkg::COORD_BITS-1:0] pos_y,
    input wire logic signed [npbc_pkg::COORD_BITS-1:0] pos_z,
    input wire logic                                   entry_valid,
    input wire logic                                   entry_last,
    input wire logic                                   done,
    input wire logic signed [npbc_pkg::COORD_BITS-1:0] near_x,
    input wire logic signed [npbc_pkg::COORD_BITS-1:0] near_y,
    input wire logic signed [npbc_pkg::COORD_BITS-1:0] near_z,
    input wire logic        [npbc_pkg::IDX_BITS-1:0]   near_index,
    input wire logic                                   found,
    input wire logic                                   overflow
);
    import npbc_pkg::*;

    logic in_beat;
    assign in_beat = start && !busy;

    // empty list gives an all-zero point
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> near_x == '0 && near_y == '0 && near_z == '0 && near_index == '0)
        else $error("empty result not zero");

    // a search starts only from a last beat
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(in_beat && entry_last))
        else $error("busy without last beat");

    // a valid last beat always leaves a point to search
    a_valid_last_search: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && entry_last && entry_valid |=> busy)
        else $error("valid last beat did not start search");

    // a plain beat never starts a search
    a_plain_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !entry_last |=> !busy)
        else $error("search without last beat");

    // a result beat follows a search or a last beat
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || (in_beat && entry_last)))
        else $error("result beat without cause");

    logic unused_ok;
    assign unused_ok = ^{pos_x, pos_y, pos_z, overflow};

endmodule

bind nearest_point_to_bbox_center_unit npbc_checker u_npbc_checker (.*);

`default_nettype wire

/* dv/nearest_point_to_bbox_center_unit_tb.sv */
module nearest_point_to_bbox_center_unit_tb;

    import npbc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [CB-1:0]   x;
        logic signed [CB-1:0]   y;
        logic signed [CB-1:0]   z;
        logic [IDX_BITS-1:0]    idx;
        logic                   hit;
        logic                   ovf;
    } near_result_t;

    typedef struct packed {
        logic signed [CB-1:0]   x;
        logic signed [CB-1:0]   y;
        logic signed [CB-1:0]   z;
        logic                   v;
        logic                   l;
        logic                   typed;
        near_result_t           ex;
    } entry_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [CB-1:0]   pos_x;
    logic signed [CB-1:0]   pos_y;
    logic signed [CB-1:0]   pos_z;
    logic                   entry_valid;
    logic                   entry_last;
    logic                   done;
    logic signed [CB-1:0]   near_x;
    logic signed [CB-1:0]   near_y;
    logic signed [CB-1:0]   near_z;
    logic [IDX_BITS-1:0]    near_index;
    logic                   found;
    logic                   overflow;

    // typed expectation travels with the beat it belongs to
    logic                   row_typed;
    near_result_t           row_expect;

    near_result_t           nearest_q[$];
    entry_row_t             dir_rows[$];
    int                     mismatches = 0;
    int                     cycle_count = 0;
    bit                     burst = 0;

    // predictor state
    logic signed [CB-1:0]   pt_x[MAX_POINTS];
    logic signed [CB-1:0]   pt_y[MAX_POINTS];
    logic signed [CB-1:0]   pt_z[MAX_POINTS];
    logic [IDX_BITS-1:0]    pt_pos[MAX_POINTS];
    logic signed [CB-1:0]   lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    int                     n_stored = 0;
    logic [10:0]            n_seen = '0;
    bit                     lost = 0;

    nearest_point_to_bbox_center_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .entry_valid (entry_valid),
        .entry_last  (entry_last),
        .done        (done),
        .near_x      (near_x),
        .near_y      (near_y),
        .near_z      (near_z),
        .near_index  (near_index),
        .found       (found),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint axis_sq(input logic signed [CB-1:0] p, lo, hi);
        longint t;
        t = 2 * longint'(p) - longint'(lo) - longint'(hi);
        return t * t;
    endfunction

    task automatic track_entry(input logic signed [CB-1:0] x, y, z, input logic v, l,
                               output bit emits, output near_result_t r);
        longint best;
        longint d;
        int slot;
        emits = 0;
        r = '0;
        if (v)
        begin
            if (n_stored < MAX_POINTS)
            begin
                pt_x[n_stored] = x;
                pt_y[n_stored] = y;
                pt_z[n_stored] = z;
                pt_pos[n_stored] = n_seen[IDX_BITS-1:0];
                if (n_stored == 0)
                begin
                    lo_x = x; hi_x = x;
                    lo_y = y; hi_y = y;
                    lo_z = z; hi_z = z;
                end
                else
                begin
                    if (x < lo_x) lo_x = x;
                    if (y < lo_y) lo_y = y;
                    if (z < lo_z) lo_z = z;
                    if (x > hi_x) hi_x = x;
                    if (y > hi_y) hi_y = y;
                    if (z > hi_z) hi_z = z;
                end
                n_stored++;
            end
            else
                lost = 1;
        end
        n_seen = n_seen + 1'b1;
        if (l)
        begin
            emits = 1;
            if (n_stored > 0)
            begin
                best = 0;
                slot = 0;
                for (int i = 0; i < n_stored; i++)
                begin
                    d = axis_sq(pt_x[i], lo_x, hi_x) + axis_sq(pt_y[i], lo_y, hi_y)
                      + axis_sq(pt_z[i], lo_z, hi_z);
                    if (i == 0 || d < best)
                    begin
                        best = d;
                        slot = i;
                    end
                end
                r.x = pt_x[slot];
                r.y = pt_y[slot];
                r.z = pt_z[slot];
                r.idx = pt_pos[slot];
                r.hit = 1'b1;
            end
            r.ovf = lost;
            n_stored = 0;
            n_seen = '0;
            lost = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    // accepted beats feed the predictor, result beats are checked in order
    always @(posedge clk)
    begin
        bit emits;
        near_result_t r;
        near_result_t want;
        if (rst_n && start && !busy)
        begin
            track_entry(pos_x, pos_y, pos_z, entry_valid, entry_last, emits, r);
            if (emits)
                nearest_q.push_back(row_typed ? row_expect : r);
        end
        if (rst_n && done)
        begin
            if (nearest_q.size() == 0)
                report_mismatch("result beat with none pending", 1, 0);
            else
            begin
                want = nearest_q.pop_front();
                if (near_x !== want.x) report_mismatch("near_x", near_x, want.x);
                if (near_y !== want.y) report_mismatch("near_y", near_y, want.y);
                if (near_z !== want.z) report_mismatch("near_z", near_z, want.z);
                if (near_index !== want.idx) report_mismatch("near_index", near_index, want.idx);
                if (found !== want.hit) report_mismatch("found", found, want.hit);
                if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
            end
        end
    end

    function automatic near_result_t mk_res(input logic signed [CB-1:0] x, y, z,
                                            input int idx, input logic hit, ovf);
        near_result_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        r.idx = IDX_BITS'(idx);
        r.hit = hit;
        r.ovf = ovf;
        return r;
    endfunction

    task automatic add_row(input logic signed [CB-1:0] x, y, z, input logic v, l, typed,
                           input near_result_t ex);
        entry_row_t row;
        row.x = x;
        row.y = y;
        row.z = z;
        row.v = v;
        row.l = l;
        row.typed = typed;
        row.ex = ex;
        dir_rows.push_back(row);
    endtask

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_entry(input logic signed [CB-1:0] x, y, z, input logic v, l, typed,
                              input near_result_t ex);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        pos_z       <= z;
        entry_valid <= v;
        entry_last  <= l;
        row_typed   <= typed;
        row_expect  <= ex;
        do @(posedge clk); while (busy);
    endtask

    // hold off until every pending result beat has come back
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (nearest_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord(input int style);
        int s;
        int t;
        s = (style == 3) ? $urandom_range(0, 2) : style;
        case (s)
            0: return CB'($urandom());
            1:
            begin
                t = $urandom_range(0, 400);
                return CB'(t - 200);
            end
            default:
                case ($urandom_range(0, 5))
                    0: return CMIN;
                    1: return CMAX;
                    2: return CB'(CMIN + 1);
                    3: return CB'(CMAX - 1);
                    4: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    task automatic random_list(input int n);
        int style;
        logic signed [CB-1:0] px, py, pz;
        logic v;
        style = $urandom_range(0, 3);
        px = '0; py = '0; pz = '0;
        for (int k = 0; k < n; k++)
        begin
            // repeated points make ties
            if (k == 0 || $urandom_range(0, 9) != 0)
            begin
                px = rand_coord(style);
                py = rand_coord(style);
                pz = rand_coord(style);
            end
            if (style == 3)
                v = ($urandom_range(0, 3) == 0);
            else
                v = ($urandom_range(0, 9) != 0);
            send_entry(px, py, pz, v, k == n - 1, 1'b0, '0);
        end
    endtask

    initial
    begin
        int made;
        int lists;
        int n;
        int t;
        logic signed [CB-1:0] px, py, pz;
        logic v;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        entry_valid <= 1'b0;
        entry_last  <= 1'b0;
        row_typed   <= 1'b0;
        row_expect  <= '0;

        // empty list
        add_row(0, 0, 0, 0, 1, 1, mk_res(0, 0, 0, 0, 0, 0));
        // single point at the low corner
        add_row(CMIN, CMIN, CMIN, 1, 1, 1, mk_res(CMIN, CMIN, CMIN, 0, 1, 0));
        // skipped entry still counts as a position
        add_row(CMIN, CMAX, 0, 0, 0, 0, '0);
        add_row(CMAX, CMAX, CMAX, 1, 1, 1, mk_res(CMAX, CMAX, CMAX, 1, 1, 0));
        // tie keeps the first point
        add_row(-8, 0, 0, 1, 0, 0, '0);
        add_row(8, 0, 0, 1, 1, 1, mk_res(-8, 0, 0, 0, 1, 0));
        // opposite extreme corners, tie at full width
        add_row(CMIN, CMAX, CMIN, 1, 0, 0, '0);
        add_row(CMAX, CMIN, CMAX, 1, 1, 1, mk_res(CMIN, CMAX, CMIN, 0, 1, 0));
        // later point nearest
        add_row(0, 0, 0, 1, 0, 0, '0);
        add_row(10, 10, 10, 1, 0, 0, '0);
        add_row(4, 4, 4, 1, 1, 1, mk_res(4, 4, 4, 2, 1, 0));
        // skipped last entry
        add_row(100, -200, 300, 1, 0, 0, '0);
        add_row(CMAX, CMAX, CMAX, 0, 1, 1, mk_res(100, -200, 300, 0, 1, 0));
        // all entries skipped
        add_row(5, 5, 5, 0, 0, 0, '0);
        add_row(CMIN, CMIN, CMIN, 0, 0, 0, '0);
        add_row(1, 2, 3, 0, 1, 1, mk_res(0, 0, 0, 0, 0, 0));
        // mixed list
        add_row(-4096, 12288, -1, 1, 0, 0, '0);
        add_row(40960, -3, 777, 0, 0, 0, '0);
        add_row(-1, -1, -1, 1, 0, 0, '0);
        add_row(2047, -65536, 524287, 1, 0, 0, '0);
        add_row(0, 1, -2, 1, 1, 0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_entry(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].v,
                       dir_rows[i].l, dir_rows[i].typed, dir_rows[i].ex);
        drain();

        // full store with dropped entries; the nearest point sits past index wrap
        for (int k = 0; k < 8 + MAX_POINTS + 4; k++)
        begin
            v = 1'b1;
            if (k < 8)
            begin
                px = CB'($urandom());
                py = CB'($urandom());
                pz = CB'($urandom());
                v = 1'b0;
            end
            else if (k == 8)
            begin
                px = -1000; py = -1000; pz = -1000;
            end
            else if (k == 9)
            begin
                px = 1000; py = 1000; pz = 1000;
            end
            else if (k < 8 + MAX_POINTS - 1)
            begin
                t = $urandom_range(1, 1000);
                px = $urandom_range(0, 1) ? CB'(t) : CB'(-t);
                t = $urandom_range(0, 2000);
                py = CB'(t - 1000);
                t = $urandom_range(0, 2000);
                pz = CB'(t - 1000);
            end
            else if (k == 8 + MAX_POINTS - 1)
            begin
                px = 0; py = 0; pz = 0;
            end
            else
            begin
                px = CMAX; py = CMIN; pz = CMAX;
            end
            if (k % 64 == 0)
                burst = ($urandom_range(0, 2) == 0);
            send_entry(px, py, pz, v, k == 8 + MAX_POINTS + 3, 1'b0, '0);
        end
        drain();

        made = 0;
        lists = 0;
        while (made < 900)
        begin
            t = $urandom_range(0, 99);
            if (t < 70)
                n = $urandom_range(1, 8);
            else if (t < 95)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(41, 150);
            burst = ($urandom_range(0, 3) == 0);
            random_list(n);
            made += n;
            lists++;
            if (lists % 8 == 0)
                drain();
        end
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
